[rtl/layer_normalization_core_assert.svh]
// Assertion macros shared by the layer normalization RTL.
// Depends on nothing; users supply signals named clock and reset.
`ifndef LAYER_NORMALIZATION_CORE_ASSERT_SVH
`define LAYER_NORMALIZATION_CORE_ASSERT_SVH

// same-cycle implication
`define LNC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lnc assertion failed");

// next-cycle implication
`define LNC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lnc assertion failed");

`endif

[rtl/lnc_pkg.sv]
// Types and fixed widths for the layer normalization core.
// No dependencies.
package lnc_pkg;

   localparam int DATA_W    = 16;   // Q8.8 sample width
   localparam int RLEN_W    = 7;    // row_length register width
   localparam int EPS_W     = 16;   // epsilon register width
   localparam int CSR_W     = 16;   // widest register
   localparam int SUM_W     = 24;   // running sum
   localparam int SQ_W      = 37;   // sum of squares
   localparam int NUM_W     = 44;   // variance numerator, divider dividend
   localparam int DEN_W     = 32;   // divider divisor
   localparam int MUL_A_W   = 38;
   localparam int MUL_B_W   = 25;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int DIV_STEPS = NUM_W;
   localparam int DCNT_W    = 6;
   localparam int ROOT_W    = 16;
   localparam int BIT_W     = 4;
   localparam int DSQ_W     = 33;

   localparam logic [RLEN_W-1:0] ROW_LENGTH_RESET = 7'd64;
   localparam logic [EPS_W-1:0]  EPSILON_RESET    = 16'd1;

   typedef enum logic [0:0] {
      CSR_ROW_LENGTH = 1'b0,
      CSR_EPSILON    = 1'b1
   } csr_index_type;

endpackage

[rtl/lnc_req_if.sv]
// Request channel of the layer normalization core: sample, scale, shift.
// Depends on lnc_pkg.
interface lnc_req_if import lnc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample;
   logic signed [DATA_W-1:0] scale;
   logic signed [DATA_W-1:0] shift;

   modport source (output valid, sample, scale, shift, input ready);
   modport sink   (input valid, sample, scale, shift, output ready);
endinterface

[rtl/lnc_rsp_if.sv]
// Result channel of the layer normalization core.
// Depends on lnc_pkg.
interface lnc_rsp_if import lnc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] normalized;
   logic signed [DATA_W-1:0] row_mean;
   logic        [DATA_W-1:0] inv_deviation;
   logic                     row_end;

   modport source (output valid, normalized, row_mean, inv_deviation, row_end, input ready);
   modport sink   (input valid, normalized, row_mean, inv_deviation, row_end, output ready);
endinterface

[rtl/layer_normalization_core.sv]
// A row of m requests loads at one request per cycle; after the last one the core runs
// a square pass, a variance divide, a mean divide and, unless v is zero, a reciprocal
// divide and a bit-serial root, then emits the row's results one at a time.
// The shared multiplier and the bit-serial divider set the pace; req.ready is low
// from the row's last request until its last result is in the output register.
// Reset (synchronous, active high): row_length 64, epsilon 1, empty row, no result held.
// Depends on lnc_pkg, lnc_req_if, lnc_rsp_if and layer_normalization_core_assert.svh.
`include "layer_normalization_core_assert.svh"

module layer_normalization_core import lnc_pkg::*; #(
   parameter int MAX_ROW = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   lnc_req_if.sink               req,
   lnc_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int IDX_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
   localparam int CNT_W = $clog2(MAX_ROW + 1);
   localparam int CMP_W = RLEN_W + 1;
   localparam int MEM_W = 3 * DATA_W;

   // one-hot sequencer
   typedef enum logic [15:0] {
      ST_LOAD     = 16'h0001,  // take requests
      ST_SQ_RD    = 16'h0002,  // square pass: read
      ST_SQ_MUL   = 16'h0004,  //   x*x
      ST_SQ_ACC   = 16'h0008,  //   accumulate
      ST_MQ       = 16'h0010,  // m*Q
      ST_SS       = 16'h0020,  // S*S
      ST_MM       = 16'h0040,  // numerator, m*m
      ST_VLOAD    = 16'h0080,  // start variance divide
      ST_VDIV     = 16'h0100,  // variance divide
      ST_MDIV     = 16'h0200,  // mean divide
      ST_RDIV     = 16'h0400,  // 2^32 / v
      ST_SQRT_MUL = 16'h0800,  // root trial square
      ST_SQRT_CMP = 16'h1000,  // root trial compare
      ST_E_RD     = 16'h2000,  // emit: read
      ST_E_MUL1   = 16'h4000,  //   (x-mean)*inv
      ST_E_MUL2   = 16'h8000   //   *gamma, then output
   } state_type;

   // config
   logic [RLEN_W-1:0]        row_length_ff;
   logic [EPS_W-1:0]         epsilon_ff;

   // sequencer and datapath registers
   state_type                state_ff, state_in;
   logic                     emit_ff, emit_in;      // result waiting for output slot
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0] mean_ff, mean_in;
   logic [DEN_W-1:0]         v_ff, v_in;
   logic [DSQ_W-1:0]         dsq_ff, dsq_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic [ROOT_W-1:0]        inv_ff, inv_in;

   // divider
   logic [DEN_W-1:0]         div_rem_ff;
   logic [NUM_W-1:0]         div_quo_ff;
   logic [DEN_W-1:0]         div_den_ff;
   logic [DCNT_W-1:0]        div_cnt_ff;
   logic                     div_load;
   logic [NUM_W-1:0]         div_dvd;
   logic [DEN_W-1:0]         div_dsr;
   logic                     div_run;
   logic [DEN_W:0]           div_shift;
   logic                     div_ge;
   logic [DEN_W:0]           div_diff;
   logic [DEN_W-1:0]         div_rem_nx;
   logic [NUM_W-1:0]         div_quo_nx;
   logic                     div_last;

   // sample store
   logic [MEM_W-1:0]         mem [MAX_ROW];
   logic [MEM_W-1:0]         rd_data_ff;
   logic                     mem_we;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] norm_ff, norm_in;
   logic                     end_ff, end_in;
   logic signed [DATA_W-1:0] omean_ff;
   logic [DATA_W-1:0]        oinv_ff;
   logic                     out_load;

   // misc
   logic                     req_acc;
   logic [RLEN_W-1:0]        row_n;
   logic                     row_done;
   logic                     last_idx;
   logic signed [DATA_W-1:0] rd_sample, rd_scale, rd_shift;
   logic signed [DATA_W:0]   diff;
   logic signed [NUM_W-1:0]  num_sub;
   logic [SUM_W-1:0]         abs_sum;
   logic [ROOT_W-1:0]        trial;
   logic signed [PROD_W-1:0] rounded;
   logic signed [CMP_W+32:0] y_full;
   logic signed [DATA_W-1:0] y_sat;

   assign req_acc   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_LOAD);

   // effective row length: 0 acts as 1, above MAX_ROW as MAX_ROW
   always_comb begin
      if (row_length_ff == '0) begin
         row_n = RLEN_W'(1);
      end else if (row_length_ff > RLEN_W'(MAX_ROW)) begin
         row_n = RLEN_W'(MAX_ROW);
      end else begin
         row_n = row_length_ff;
      end
   end

   assign row_done = (CMP_W'(fill_ff) + CMP_W'(1)) >= CMP_W'(row_n);
   assign last_idx = CNT_W'(idx_ff) == (fill_ff - CNT_W'(1));

   assign rd_sample = rd_data_ff[DATA_W-1:0];
   assign rd_scale  = rd_data_ff[2*DATA_W-1:DATA_W];
   assign rd_shift  = rd_data_ff[3*DATA_W-1:2*DATA_W];

   // store: one write port at the fill position, one registered read port at idx
   assign mem_we = req_acc;
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_ff[IDX_W-1:0]] <= {req.shift, req.scale, req.sample};
      end
      rd_data_ff <= mem[idx_ff];
   end

   // bit-serial restoring divider, one quotient bit per cycle
   assign div_run    = (state_ff == ST_VDIV) || (state_ff == ST_MDIV) || (state_ff == ST_RDIV);
   assign div_shift  = {div_rem_ff, div_quo_ff[NUM_W-1]};
   assign div_diff   = div_shift - {1'b0, div_den_ff};
   assign div_ge     = div_shift >= {1'b0, div_den_ff};
   assign div_rem_nx = div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
   assign div_quo_nx = {div_quo_ff[NUM_W-2:0], div_ge};
   assign div_last   = div_cnt_ff == DCNT_W'(DIV_STEPS - 1);

   always_ff @(posedge clock) begin
      if (div_load) begin
         div_rem_ff <= '0;
         div_quo_ff <= div_dvd;
         div_den_ff <= div_dsr;
         div_cnt_ff <= '0;
      end else if (div_run) begin
         div_rem_ff <= div_rem_nx;
         div_quo_ff <= div_quo_nx;
         div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
      end
   end

   assign mul_p = mul_a * mul_b;

   assign diff    = (DATA_W+1)'(rd_sample) - (DATA_W+1)'(mean_ff);
   assign num_sub = num_ff - prod_ff[NUM_W-1:0];
   assign abs_sum = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign trial   = root_ff | (ROOT_W'(1) << bit_ff);

   // round half up at 2^-16, add beta, saturate to Q8.8
   assign rounded = (prod_ff + PROD_W'(32768)) >>> 16;
   assign y_full  = (CMP_W+33)'(rounded) + (CMP_W+33)'(rd_shift);
   always_comb begin
      if (y_full > (CMP_W+33)'(32767)) begin
         y_sat = 16'sh7FFF;
      end else if (y_full < -(CMP_W+33)'(32768)) begin
         y_sat = -16'sh8000;
      end else begin
         y_sat = y_full[DATA_W-1:0];
      end
   end

   assign out_load = emit_ff && (!rsp_valid_ff || rsp.ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      emit_in      = emit_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      num_in       = num_ff;
      prod_in      = prod_ff;
      mean_in      = mean_ff;
      v_in         = v_ff;
      dsq_in       = dsq_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      inv_in       = inv_ff;
      div_load     = 1'b0;
      div_dvd      = '0;
      div_dsr      = '0;
      mul_a        = '0;
      mul_b        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      norm_in      = norm_ff;
      end_in       = end_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               sum_in  = sum_ff + SUM_W'(req.sample);
               fill_in = fill_ff + CNT_W'(1);
               if (row_done) begin
                  idx_in   = '0;
                  sq_in    = '0;
                  state_in = ST_SQ_RD;
               end
            end
         end
         ST_SQ_RD: begin
            state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            mul_a    = MUL_A_W'(rd_sample);
            mul_b    = MUL_B_W'(rd_sample);
            prod_in  = mul_p;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            sq_in = sq_ff + prod_ff[SQ_W-1:0];
            if (last_idx) begin
               state_in = ST_MQ;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SQ_RD;
            end
         end
         ST_MQ: begin
            mul_a    = MUL_A_W'($signed({1'b0, sq_ff}));
            mul_b    = MUL_B_W'($signed({1'b0, fill_ff}));
            prod_in  = mul_p;
            state_in = ST_SS;
         end
         ST_SS: begin
            num_in   = prod_ff[NUM_W-1:0];
            mul_a    = MUL_A_W'(sum_ff);
            mul_b    = MUL_B_W'(sum_ff);
            prod_in  = mul_p;
            state_in = ST_MM;
         end
         ST_MM: begin
            num_in   = num_sub[NUM_W-1] ? '0 : num_sub;
            mul_a    = MUL_A_W'($signed({1'b0, fill_ff}));
            mul_b    = MUL_B_W'($signed({1'b0, fill_ff}));
            prod_in  = mul_p;
            state_in = ST_VLOAD;
         end
         ST_VLOAD: begin
            div_load = 1'b1;
            div_dvd  = num_ff;
            div_dsr  = prod_ff[DEN_W-1:0];
            state_in = ST_VDIV;
         end
         ST_VDIV: begin
            if (div_last) begin
               v_in     = div_quo_nx[DEN_W-1:0] + DEN_W'(epsilon_ff);
               // floor division for a negative sum: -((|S| + m - 1) / m)
               div_load = 1'b1;
               div_dvd  = sum_ff[SUM_W-1] ?
                          NUM_W'(abs_sum) + NUM_W'(fill_ff) - NUM_W'(1) : NUM_W'(abs_sum);
               div_dsr  = DEN_W'(fill_ff);
               state_in = ST_MDIV;
            end
         end
         ST_MDIV: begin
            if (div_last) begin
               mean_in = sum_ff[SUM_W-1] ? -div_quo_nx[DATA_W-1:0] : div_quo_nx[DATA_W-1:0];
               if (v_ff == '0) begin
                  inv_in   = '1;
                  idx_in   = '0;
                  state_in = ST_E_RD;
               end else begin
                  div_load = 1'b1;
                  div_dvd  = NUM_W'(1) << 32;
                  div_dsr  = v_ff;
                  state_in = ST_RDIV;
               end
            end
         end
         ST_RDIV: begin
            if (div_last) begin
               dsq_in   = div_quo_nx[DSQ_W-1:0];
               root_in  = '0;
               bit_in   = BIT_W'(ROOT_W - 1);
               state_in = ST_SQRT_MUL;
            end
         end
         ST_SQRT_MUL: begin
            mul_a    = MUL_A_W'($signed({1'b0, trial}));
            mul_b    = MUL_B_W'($signed({1'b0, trial}));
            prod_in  = mul_p;
            state_in = ST_SQRT_CMP;
         end
         ST_SQRT_CMP: begin
            if (prod_ff[DSQ_W-1:0] <= dsq_ff) begin
               root_in = trial;
            end
            if (bit_ff == '0) begin
               inv_in   = (prod_ff[DSQ_W-1:0] <= dsq_ff) ? trial : root_ff;
               idx_in   = '0;
               state_in = ST_E_RD;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = ST_SQRT_MUL;
            end
         end
         ST_E_RD: begin
            state_in = ST_E_MUL1;
         end
         ST_E_MUL1: begin
            mul_a    = MUL_A_W'(diff);
            mul_b    = MUL_B_W'($signed({1'b0, inv_ff}));
            prod_in  = mul_p;
            state_in = ST_E_MUL2;
         end
         ST_E_MUL2: begin
            if (!emit_ff) begin
               // signed 34-bit (x-mean)*inv times gamma
               mul_a   = MUL_A_W'($signed(prod_ff[2*DATA_W+1:0]));
               mul_b   = MUL_B_W'(rd_scale);
               prod_in = mul_p;
               emit_in = 1'b1;
            end else if (out_load) begin
               // result goes to the output register
               emit_in      = 1'b0;
               rsp_valid_in = 1'b1;
               norm_in      = y_sat;
               end_in       = last_idx;
               if (last_idx) begin
                  fill_in  = '0;
                  sum_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_E_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         emit_ff       <= 1'b0;
         fill_ff       <= '0;
         idx_ff        <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         row_length_ff <= ROW_LENGTH_RESET;
         epsilon_ff    <= EPSILON_RESET;
      end else begin
         state_ff     <= state_in;
         emit_ff      <= emit_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_ROW_LENGTH: row_length_ff <= csr_wdata[RLEN_W-1:0];
               CSR_EPSILON:    epsilon_ff    <= csr_wdata[EPS_W-1:0];
               default:        row_length_ff <= row_length_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      mean_ff <= mean_in;
      v_ff    <= v_in;
      dsq_ff  <= dsq_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      inv_ff  <= inv_in;
      norm_ff <= norm_in;
      end_ff  <= end_in;
      if (out_load) begin
         omean_ff <= mean_ff;
         oinv_ff  <= inv_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.normalized    = norm_ff;
   assign rsp.row_mean      = omean_ff;
   assign rsp.inv_deviation = oinv_ff;
   assign rsp.row_end       = end_ff;

   // a completed row stops intake on the next cycle
   `LNC_ASSERT_NEXT(a_row_stops_intake, req_acc && row_done, !req.ready)
   // while taking requests the row never holds a full store
   `LNC_ASSERT_NOW(a_fill_bound, state_ff == ST_LOAD, fill_ff < CNT_W'(MAX_ROW))
   // loading the row's last result empties the row
   `LNC_ASSERT_NEXT(a_row_cleared, out_load && last_idx, fill_ff == '0 && sum_ff == '0)

endmodule

[bench/tb_layer_normalization_core.sv]
// Self-checking testbench for layer_normalization_core: rows of requests, Q8.8 results.
// Depends on lnc_pkg, lnc_req_if, lnc_rsp_if and the core RTL.
module tb_layer_normalization_core;
   import lnc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_MAX     = 64;
   localparam int CYCLE_LIMIT = 2000000;  // watchdog limit on the whole run
   localparam int SETTLE      = 300;      // core latency headroom before register writes

   typedef struct {
      logic signed [DATA_W-1:0] normalized;
      logic signed [DATA_W-1:0] row_mean;
      logic        [DATA_W-1:0] inv_deviation;
      logic                     row_end;
   } lnc_result_type;

   // Row buffer, statistics and expected-result queue for the core.
   class lnc_scoreboard_type;
      logic signed [DATA_W-1:0] samples [ROW_MAX];
      logic signed [DATA_W-1:0] scales  [ROW_MAX];
      logic signed [DATA_W-1:0] shifts  [ROW_MAX];
      int             fill;
      longint         total;
      int unsigned    row_len;
      int unsigned    eps;
      lnc_result_type expected [$];
      int             errors;

      function new();
         row_len = 64;
         eps     = 1;
         fill    = 0;
         total   = 0;
         errors  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
         if (idx == CSR_ROW_LENGTH) begin
            row_len = 32'(value[RLEN_W-1:0]);
         end else begin
            eps = 32'(value);
         end
      endfunction

      static function longint floor_div(longint a, longint d);
         if (a >= 0) begin
            return a / d;
         end
         return -((-a + d - 1) / d);
      endfunction

      // largest q with q*q*v <= 2^32
      static function longint unsigned inv_sqrt(longint unsigned v);
         longint unsigned lo, hi, mid;
         lo = 0;
         hi = 65535;
         if (v == 0) begin
            return 65535;
         end
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * v <= 64'h1_0000_0000) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         return lo;
      endfunction

      function void note_request(logic signed [DATA_W-1:0] s, logic signed [DATA_W-1:0] g,
                                 logic signed [DATA_W-1:0] b);
         int unsigned     n;
         int              m;
         longint          sq, mean, num, p, y;
         longint unsigned variance, inv;
         lnc_result_type  r;
         n = (row_len < 1) ? 1 : (row_len > ROW_MAX) ? ROW_MAX : row_len;
         if (fill < ROW_MAX) begin
            samples[fill] = s;
            scales[fill]  = g;
            shifts[fill]  = b;
            total += longint'(s);
            fill++;
         end
         if (fill < n) begin
            return;
         end
         m  = fill;
         sq = 0;
         for (int i = 0; i < m; i++) begin
            sq += longint'(samples[i]) * longint'(samples[i]);
         end
         mean = floor_div(total, m);
         num  = longint'(m) * sq - total * total;
         if (num < 0) begin
            num = 0;
         end
         variance = longint'(num) / (longint'(m) * m);
         inv      = inv_sqrt(variance + eps);
         for (int i = 0; i < m; i++) begin
            p = (longint'(samples[i]) - mean) * longint'(inv) * longint'(scales[i]);
            y = ((p + 32768) >>> 16) + longint'(shifts[i]);
            if (y > 32767) begin
               y = 32767;
            end else if (y < -32768) begin
               y = -32768;
            end
            r.normalized    = y[DATA_W-1:0];
            r.row_mean      = mean[DATA_W-1:0];
            r.inv_deviation = inv[DATA_W-1:0];
            r.row_end       = (i == m - 1);
            expected.insert(expected.size(), r);
         end
         fill  = 0;
         total = 0;
      endfunction

      function void check_result(lnc_result_type got);
         lnc_result_type want;
         if (expected.size() == 0) begin
            $display("%0t: unexpected result normalized=%0d mean=%0d inv=%0d end=%0b", $time,
                     got.normalized, got.row_mean, got.inv_deviation, got.row_end);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (got.normalized !== want.normalized) begin
            $display("%0t: normalized expected %0d actual %0d", $time,
                     want.normalized, got.normalized);
            errors++;
         end
         if (got.row_mean !== want.row_mean) begin
            $display("%0t: row_mean expected %0d actual %0d", $time,
                     want.row_mean, got.row_mean);
            errors++;
         end
         if (got.inv_deviation !== want.inv_deviation) begin
            $display("%0t: inv_deviation expected %0d actual %0d", $time,
                     want.inv_deviation, got.inv_deviation);
            errors++;
         end
         if (got.row_end !== want.row_end) begin
            $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, got.row_end);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   csr_index_type      csr_index = CSR_ROW_LENGTH;
   logic [CSR_W-1:0]   csr_wdata = '0;
   bit                 calm = 1'b0;     // when set, neither side idles
   int                 cycles = 0;
   lnc_scoreboard_type sb = new();

   lnc_req_if req ();
   lnc_rsp_if rsp ();

   layer_normalization_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid  = 1'b0;
      req.sample = '0;
      req.scale  = '0;
      req.shift  = '0;
      rsp.ready  = 1'b0;
   end

   // Result side: random backpressure, changed on the falling edge.
   always @(negedge clock) begin
      rsp.ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= 8);
   end

   // Result capture on the rising edge.
   always @(posedge clock) begin
      lnc_result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.normalized    = rsp.normalized;
         got.row_mean      = rsp.row_mean;
         got.inv_deviation = rsp.inv_deviation;
         got.row_end       = rsp.row_end;
         sb.check_result(got);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL layer_normalization_core");
         $finish;
      end
   end

   // Called and returns at a falling edge; valid stays high for back-to-back requests.
   task automatic push_request(input logic signed [DATA_W-1:0] s,
                               input logic signed [DATA_W-1:0] g,
                               input logic signed [DATA_W-1:0] b);
      while (!calm && $urandom_range(99) < 8) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid  = 1'b1;
      req.sample = s;
      req.scale  = g;
      req.shift  = b;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      sb.note_request(s, g, b);
      @(negedge clock);
   endtask

   // Drain all expected results, let the core settle, then write a register.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] value);
      req.valid = 1'b0;
      while (sb.expected.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(idx, value);
   endtask

   // Random sample: full range, clustered around a center, or a fixed value.
   function automatic logic signed [DATA_W-1:0] pick_sample(int style,
                                                             logic signed [DATA_W-1:0] center);
      int v;
      case (style)
         0: begin
            return DATA_W'($urandom);
         end
         1: begin
            v = int'(center) + $urandom_range(512) - 256;
            return (v > 32767) ? 16'sd32767 : (v < -32768) ? -16'sd32768 : v[DATA_W-1:0];
         end
         default: begin
            return center;
         end
      endcase
   endfunction

   initial begin
      int                       sent, lens[9], n, style;
      logic signed [DATA_W-1:0] center;
      lens = '{1, 2, 3, 4, 5, 8, 16, 0, 64};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero variance with zero epsilon saturates the inverse deviation.
      write_csr(CSR_ROW_LENGTH, 16'd4);
      write_csr(CSR_EPSILON, 16'd0);
      repeat (4) push_request(16'sd0, 16'sd256, 16'sd0);
      // full-scale samples, weights and biases
      push_request(-16'sd32768, 16'sd32767, 16'sd32767);
      push_request(16'sd32767, -16'sd32768, -16'sd32768);
      push_request(-16'sd32768, -16'sd32768, 16'sd32767);
      push_request(16'sd32767, 16'sd32767, -16'sd32768);
      // ordinary row that stays in range
      push_request(16'sd256, 16'sd256, 16'sd0);
      push_request(-16'sd256, 16'sd128, 16'sd64);
      push_request(16'sd512, 16'sd256, -16'sd64);
      push_request(16'sd0, 16'sd512, 16'sd100);
      // one-sample rows, then a zero length taken as one
      write_csr(CSR_EPSILON, 16'hFFFF);
      write_csr(CSR_ROW_LENGTH, 16'd1);
      push_request(16'sh1234, -16'sd1, 16'sh5A5A);
      write_csr(CSR_ROW_LENGTH, 16'd0);
      push_request(-16'sd1, 16'sd1, -16'sd1);
      // length lowered mid-row: three held, next request closes a row of four
      write_csr(CSR_ROW_LENGTH, 16'd5);
      repeat (3) push_request(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
      write_csr(CSR_ROW_LENGTH, 16'd2);
      push_request(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
      // length above the maximum is clamped to a full row
      write_csr(CSR_ROW_LENGTH, 16'd100);

      // Random phases; the middle stretch runs without any idling.
      sent = 0;
      while (sent < 350) begin
         calm = (sent > 120 && sent < 200);
         if (sent > 0) begin
            n = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 64 : 127) :
                lens[$urandom_range(7)];
            write_csr(CSR_ROW_LENGTH, n[CSR_W-1:0]);
            case ($urandom_range(3))
               0:       write_csr(CSR_EPSILON, 16'd0);
               1:       write_csr(CSR_EPSILON, 16'hFFFF);
               default: write_csr(CSR_EPSILON, CSR_W'($urandom));
            endcase
         end
         n = (sb.row_len < 1) ? 1 : (sb.row_len > ROW_MAX) ? ROW_MAX : sb.row_len;
         // a few full rows, sometimes leaving a partial row held at the end
         for (int r = 0; r < $urandom_range(3, 1) && sent < 350; r++) begin
            style  = $urandom_range(2);
            center = DATA_W'($urandom);
            for (int k = 0; k < n; k++) begin
               push_request(pick_sample(style, center), DATA_W'($urandom), DATA_W'($urandom));
               sent++;
            end
         end
         if ($urandom_range(3) == 0 && n > 1) begin
            repeat ($urandom_range(n - 1, 1)) begin
               push_request(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
               sent++;
            end
         end
      end
      calm = 1'b0;
      req.valid = 1'b0;

      while (sb.expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS layer_normalization_core");
      end else begin
         $display("FAIL layer_normalization_core");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/lnc_pkg.sv
rtl/lnc_req_if.sv
rtl/lnc_rsp_if.sv
rtl/layer_normalization_core.sv
bench/tb_layer_normalization_core.sv
